@@ src/tcs_pkg.sv @@
// Package for the touch calibration solver: widths, constants, types.
// No dependencies.
package tcs_pkg;

    localparam int MaxPoints = 256;
    localparam int CntW      = $clog2(MaxPoints + 1);
    localparam int SumW      = 16 + CntW;
    localparam int SsumW     = 12 + CntW;
    localparam int CfgIdxW   = 1;
    localparam int CfgW      = 13;
    localparam int DivW      = 48;

    localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_CNT  = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_DEGEN    = 3'd3;
    localparam logic [2:0] ST_TOO_MANY = 3'd4;

    typedef enum logic [3:0] {
        S_COLLECT,
        S_MEAN,
        S_MEAN_WAIT,
        S_SWAP,
        S_MUL,
        S_EDGE,
        S_EDGE_WAIT,
        S_FIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic mean_start;
        logic swap;
        logic mul;
        logic edge_start;
        logic fit;
        logic out_valid;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic mean_last;
        logic edge_last;
        logic early_err;
    } sts_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        swap_xy;
        logic        inv_x;
        logic        inv_y;
        logic [15:0] x_min;
        logic [15:0] x_max;
        logic [15:0] y_min;
        logic [15:0] y_max;
    } result_t;

    typedef struct packed {
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic [11:0] scr_x;
        logic [11:0] scr_y;
        logic        last_point;
    } point_t;

endpackage

@@ src/tcs_stream_if.sv @@
// Valid/ready channel interface carrying one item of type T.
// No dependencies; the payload type T is a parameter.
interface tcs_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/tcs_divider.sv @@
// Restoring signed divider, one quotient bit per cycle, truncating.
// Depends on tcs_pkg.
module tcs_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [tcs_pkg::DivW-1:0] dividend,
    input  logic signed [tcs_pkg::DivW-1:0] divisor,
    output logic                          done,
    output logic signed [tcs_pkg::DivW-1:0] quotient
);
    import tcs_pkg::*;

    localparam int CW = $clog2(DivW + 1);

    logic [DivW-1:0] rem_reg, rem_next;
    logic [DivW-1:0] quo_reg, quo_next;
    logic [DivW-1:0] den_reg, den_next;
    logic            neg_reg, neg_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DivW:0]   trial;
    logic [DivW-1:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DivW-2:0], quo_reg[DivW-1]};
        trial     = {1'b0, shifted} - {1'b0, den_reg};
        if (start)
        begin
            quo_next  = dividend[DivW-1] ? DivW'(-dividend) : dividend;
            den_next  = divisor[DivW-1] ? DivW'(-divisor) : divisor;
            neg_next  = dividend[DivW-1] ^ divisor[DivW-1];
            rem_next  = '0;
            cnt_next  = CW'(DivW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[DivW])
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DivW-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[DivW-1:0];
                quo_next = {quo_reg[DivW-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? DivW'(-quo_reg) : quo_reg;
endmodule

@@ src/tcs_datapath.sv @@
// Accumulators, mean and edge computation through one shared divider.
// Depends on tcs_pkg and tcs_divider.
module tcs_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         acc_en,
    input  tcs_pkg::point_t              pt,
    input  logic [tcs_pkg::CfgW-1:0]     width_cfg,
    input  logic [tcs_pkg::CfgW-1:0]     height_cfg,
    input  tcs_pkg::cmd_t                cmd,
    output tcs_pkg::sts_t                sts,
    output tcs_pkg::result_t             result
);
    import tcs_pkg::*;

    // means: 0..2 raw_x/raw_y/screen for xsplit lo, ... indexes below
    // order: xs lo {rx,ry,s}, xs hi {rx,ry,s}, ys lo {rx,ry,s}, ys hi {rx,ry,s}
    localparam int NMean = 12;
    localparam int MW    = $clog2(NMean);
    // edge values before clamping reach about +-2^30
    localparam int EW    = 34;

    logic [SumW-1:0]  xrx_reg [2];
    logic [SumW-1:0]  xry_reg [2];
    logic [SsumW-1:0] xs_reg  [2];
    logic [CntW-1:0]  xc_reg  [2];
    logic [SumW-1:0]  yrx_reg [2];
    logic [SumW-1:0]  yry_reg [2];
    logic [SsumW-1:0] ys_reg  [2];
    logic [CntW-1:0]  yc_reg  [2];
    logic [CntW-1:0]  tot_reg;
    logic             ovf_reg;

    logic [15:0]      mean_reg [NMean];
    logic [MW-1:0]    midx_reg;
    logic             swap_reg;
    logic             ax_reg;      // 0: x axis, 1: y axis
    logic             end_reg;     // 0: pixel 0 end, 1: last pixel end
    logic signed [DivW-1:0] prod_reg;
    logic signed [DivW-1:0] ds_reg;
    logic signed [EW-1:0]   e0_reg;
    logic             degen_reg;
    logic [15:0]      xl_reg, xh_reg, yl_reg, yh_reg;
    logic             ix_reg, iy_reg;
    result_t          res_reg;
    result_t          res_next;

    logic [11:0] midx, midy;
    logic        hx, hy;
    logic [SumW-1:0] msum;
    logic [CntW-1:0] mcnt;
    logic        div_start;
    logic signed [DivW-1:0] dvd, dvs, quo;
    logic        div_done;

    assign midx = (width_cfg == '0) ? 12'd0 : 12'((width_cfg - 1'b1) >> 1);
    assign midy = (height_cfg == '0) ? 12'd0 : 12'((height_cfg - 1'b1) >> 1);
    assign hx   = pt.scr_x > midx;
    assign hy   = pt.scr_y > midy;

    always_comb
    begin
        unique case (midx_reg)
            4'd0:  begin msum = xrx_reg[0]; mcnt = xc_reg[0]; end
            4'd1:  begin msum = xry_reg[0]; mcnt = xc_reg[0]; end
            4'd2:  begin msum = SumW'(xs_reg[0]); mcnt = xc_reg[0]; end
            4'd3:  begin msum = xrx_reg[1]; mcnt = xc_reg[1]; end
            4'd4:  begin msum = xry_reg[1]; mcnt = xc_reg[1]; end
            4'd5:  begin msum = SumW'(xs_reg[1]); mcnt = xc_reg[1]; end
            4'd6:  begin msum = yrx_reg[0]; mcnt = yc_reg[0]; end
            4'd7:  begin msum = yry_reg[0]; mcnt = yc_reg[0]; end
            4'd8:  begin msum = SumW'(ys_reg[0]); mcnt = yc_reg[0]; end
            4'd9:  begin msum = yrx_reg[1]; mcnt = yc_reg[1]; end
            4'd10: begin msum = yry_reg[1]; mcnt = yc_reg[1]; end
            4'd11: begin msum = SumW'(ys_reg[1]); mcnt = yc_reg[1]; end
            default: begin msum = '0; mcnt = CntW'(1); end
        endcase
    end

    // fit inputs for current axis (after swap)
    logic [15:0] rlo, rhi, slo, shi;
    logic [CfgW-1:0] pix;
    logic signed [17:0] dr;
    logic signed [13:0] dsn, mulb;
    logic signed [EW-1:0] qe, e1c, e0c;
    logic [15:0] ea, eb;

    always_comb
    begin
        if (!ax_reg)
        begin
            rlo = swap_reg ? mean_reg[1] : mean_reg[0];
            rhi = swap_reg ? mean_reg[4] : mean_reg[3];
            slo = mean_reg[2];
            shi = mean_reg[5];
            pix = width_cfg;
        end
        else
        begin
            rlo = swap_reg ? mean_reg[6] : mean_reg[7];
            rhi = swap_reg ? mean_reg[9] : mean_reg[10];
            slo = mean_reg[8];
            shi = mean_reg[11];
            pix = height_cfg;
        end
        dr   = 18'(signed'({2'b00, rhi})) - 18'(signed'({2'b00, rlo}));
        dsn  = 14'(signed'({2'b00, shi[11:0]})) - 14'(signed'({2'b00, slo[11:0]}));
        mulb = end_reg ? 14'(signed'({1'b0, pix})) - 14'sd1 - 14'(signed'({2'b00, slo[11:0]}))
                       : 14'(signed'({2'b00, slo[11:0]}));
        qe   = EW'(quo);
        e1c  = end_reg ? EW'(signed'({2'b00, rlo})) + qe : EW'(signed'({2'b00, rlo})) - qe;
        e0c  = e0_reg;
        ea   = e0c[EW-1] ? 16'd0 : (e0c > EW'(65535) ? 16'hFFFF : e0c[15:0]);
        eb   = e1c[EW-1] ? 16'd0 : (e1c > EW'(65535) ? 16'hFFFF : e1c[15:0]);
    end

    assign div_start = cmd.mean_start | cmd.edge_start;
    assign dvd = cmd.mean_start ? DivW'(msum) : prod_reg;
    assign dvs = cmd.mean_start ? ((mcnt == '0) ? DivW'(1) : DivW'(mcnt)) : ds_reg;

    tcs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                xrx_reg[i] <= '0; xry_reg[i] <= '0; xs_reg[i] <= '0; xc_reg[i] <= '0;
                yrx_reg[i] <= '0; yry_reg[i] <= '0; ys_reg[i] <= '0; yc_reg[i] <= '0;
            end
            tot_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < 2; i++)
            begin
                xrx_reg[i] <= '0; xry_reg[i] <= '0; xs_reg[i] <= '0; xc_reg[i] <= '0;
                yrx_reg[i] <= '0; yry_reg[i] <= '0; ys_reg[i] <= '0; yc_reg[i] <= '0;
            end
            tot_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (acc_en)
        begin
            if (tot_reg >= CntW'(MaxPoints))
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                xrx_reg[hx] <= xrx_reg[hx] + SumW'(pt.raw_x);
                xry_reg[hx] <= xry_reg[hx] + SumW'(pt.raw_y);
                xs_reg[hx]  <= xs_reg[hx] + SsumW'(pt.scr_x);
                xc_reg[hx]  <= xc_reg[hx] + 1'b1;
                yrx_reg[hy] <= yrx_reg[hy] + SumW'(pt.raw_x);
                yry_reg[hy] <= yry_reg[hy] + SumW'(pt.raw_y);
                ys_reg[hy]  <= ys_reg[hy] + SsumW'(pt.scr_y);
                yc_reg[hy]  <= yc_reg[hy] + 1'b1;
                tot_reg     <= tot_reg + 1'b1;
            end
        end
    end

    logic [15:0] dx, dy;
    assign dx = (mean_reg[3] > mean_reg[0]) ? mean_reg[3] - mean_reg[0]
                                            : mean_reg[0] - mean_reg[3];
    assign dy = (mean_reg[9] > mean_reg[6]) ? mean_reg[9] - mean_reg[6]
                                            : mean_reg[6] - mean_reg[9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midx_reg <= '0;
            ax_reg   <= 1'b0;
            end_reg  <= 1'b0;
            degen_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                midx_reg  <= '0;
                ax_reg    <= 1'b0;
                end_reg   <= 1'b0;
                degen_reg <= 1'b0;
            end
            if (div_done && midx_reg != MW'(NMean))
                midx_reg <= midx_reg + 1'b1;
            if (cmd.fit)
            begin
                ax_reg  <= ~ax_reg;
                end_reg <= 1'b0;
            end
            else if (div_done && midx_reg == MW'(NMean) && !end_reg)
                end_reg <= 1'b1;
            if (cmd.mul && (shi[11:0] <= slo[11:0] || rlo == rhi))
                degen_reg <= 1'b1;
            if (cmd.fit && ea == eb)
                degen_reg <= 1'b1;
        end
    end

    always_comb
    begin
        res_next = '0;
        if (ovf_reg)
            res_next.status = ST_TOO_MANY;
        else if (tot_reg < CntW'(2) || width_cfg < CfgW'(2) || height_cfg < CfgW'(2))
            res_next.status = ST_BAD_CNT;
        else if (xc_reg[0] == '0 || xc_reg[1] == '0 || yc_reg[0] == '0 || yc_reg[1] == '0)
            res_next.status = ST_EMPTY;
        else if (degen_reg)
            res_next.status = ST_DEGEN;
        else
        begin
            res_next.status  = ST_OK;
            res_next.swap_xy = swap_reg;
            res_next.inv_x   = ix_reg;
            res_next.inv_y   = iy_reg;
            res_next.x_min   = xl_reg;
            res_next.x_max   = xh_reg;
            res_next.y_min   = yl_reg;
            res_next.y_max   = yh_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done && midx_reg != MW'(NMean))
            mean_reg[midx_reg] <= quo[15:0];
        if (cmd.swap)
            swap_reg <= dy > dx;
        if (cmd.mul)
        begin
            prod_reg <= DivW'(dr * 32'(mulb));
            ds_reg   <= DivW'(dsn);
        end
        if (div_done && midx_reg == MW'(NMean) && !end_reg)
            e0_reg <= e1c;
        if (cmd.fit)
        begin
            if (!ax_reg)
            begin
                xl_reg <= (ea < eb) ? ea : eb;
                xh_reg <= (ea < eb) ? eb : ea;
                ix_reg <= ea > eb;
            end
            else
            begin
                yl_reg <= (ea < eb) ? ea : eb;
                yh_reg <= (ea < eb) ? eb : ea;
                iy_reg <= ea > eb;
            end
        end
        if (cmd.out_valid)
            res_reg <= res_next;
    end

    assign sts.div_done  = div_done;
    assign sts.mean_last = (midx_reg == MW'(NMean - 1));
    assign sts.edge_last = end_reg;
    assign sts.early_err = ovf_reg || tot_reg < CntW'(2) || width_cfg < CfgW'(2)
                        || height_cfg < CfgW'(2) || xc_reg[0] == '0 || xc_reg[1] == '0
                        || yc_reg[0] == '0 || yc_reg[1] == '0;
    assign result        = res_reg;
endmodule

@@ src/tcs_control.sv @@
// Sequencer for collect, mean, swap, two-axis fit and result handoff.
// Depends on tcs_pkg.
module tcs_control (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  logic          in_last,
    input  logic          out_ready,
    input  tcs_pkg::sts_t sts,
    output tcs_pkg::cmd_t cmd,
    output logic          in_ready,
    output logic          out_valid
);
    import tcs_pkg::*;

    state_t state_reg, state_next;
    logic   ax_reg, ax_next;
    logic   ov_reg, ov_next;
    // accumulators clear the cycle after the result is latched
    logic   clr_reg;

    always_comb
    begin
        state_next = state_reg;
        ax_next    = ax_reg;
        unique case (state_reg)
            S_COLLECT:   if (in_fire && in_last) state_next = S_MEAN;
            S_MEAN:      state_next = S_MEAN_WAIT;
            S_MEAN_WAIT:
                if (sts.div_done)
                    state_next = sts.mean_last ? S_SWAP : S_MEAN;
            S_SWAP:
            begin
                ax_next    = 1'b0;
                state_next = sts.early_err ? S_OUT : S_MUL;
            end
            S_MUL:       state_next = S_EDGE;
            S_EDGE:      state_next = S_EDGE_WAIT;
            S_EDGE_WAIT:
                if (sts.div_done)
                    state_next = sts.edge_last ? S_FIT : S_MUL;
            S_FIT:
            begin
                ax_next    = 1'b1;
                state_next = ax_reg ? S_OUT : S_MUL;
            end
            S_OUT:       state_next = S_COLLECT;
            default:     state_next = S_COLLECT;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_MEAN:  cmd.mean_start = 1'b1;
            S_SWAP:  cmd.swap       = 1'b1;
            S_MUL:   cmd.mul        = 1'b1;
            S_EDGE:  cmd.edge_start = 1'b1;
            S_FIT:   cmd.fit        = 1'b1;
            S_OUT:   cmd.out_valid  = 1'b1;
            default: cmd = '0;
        endcase
        cmd.clear = clr_reg;
    end

    // result register holds until taken
    always_comb
    begin
        ov_next = ov_reg;
        if (cmd.out_valid)
            ov_next = 1'b1;
        else if (ov_reg && out_ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
            ax_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            clr_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
            ov_reg    <= ov_next;
            clr_reg   <= cmd.out_valid;
        end
    end

    assign in_ready  = (state_reg == S_COLLECT) && !clr_reg && !(ov_reg && !out_ready);
    assign out_valid = ov_reg;
endmodule

@@ src/touch_calibration_solver.sv @@
// Top level of the touch calibration solver.
// Depends on tcs_pkg, tcs_stream_if, tcs_control, tcs_datapath.
//
// channel  dir   payload
// pt_in    sink  raw_x raw_y scr_x scr_y last_point
// res_out  src   status swap_xy inv_x inv_y x_min x_max y_min y_max
// cfg      in    cfg_we cfg_index cfg_data
//
// Points are taken one per cycle while collecting. After a last point the solve
// runs a mean per sum, a swap step, an edge division per end and a fit per axis,
// the divisions on the shared 48-bit divider, then an output step. When the status
// is settled after the means, the output step follows the swap directly.
// One clear cycle follows the result; a waiting result blocks points until taken.
// Reset clears all sums and counts and sets sizes to 320 by 240.
module touch_calibration_solver (
    input  logic                         clk,
    input  logic                         rst_n,
    tcs_stream_if.sink                   pt_in,
    tcs_stream_if.source                 res_out,
    input  logic                         cfg_we,
    input  logic [tcs_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [tcs_pkg::CfgW-1:0]     cfg_data
);
    import tcs_pkg::*;

    logic [CfgW-1:0] width_reg, height_reg;
    cmd_t    cmd;
    sts_t    sts;
    result_t result;
    logic    in_fire;
    point_t  pt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CfgW'(320);
            height_reg <= CfgW'(240);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    assign pt      = pt_in.data;
    assign in_fire = pt_in.valid && pt_in.ready;

    tcs_control u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_last   (pt.last_point),
        .out_ready (res_out.ready),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (pt_in.ready),
        .out_valid (res_out.valid)
    );

    tcs_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc_en     (in_fire),
        .pt         (pt),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .cmd        (cmd),
        .sts        (sts),
        .result     (result)
    );

    assign res_out.data = result;
endmodule
